// ===== design/dns_name_label_encoder_core_macros.svh =====
// Assertion helpers for the DNS label encoder. Both sample on clock and are off in reset.
`ifndef DNS_NAME_LABEL_ENCODER_CORE_MACROS_SVH
`define DNS_NAME_LABEL_ENCODER_CORE_MACROS_SVH

`ifndef SYNTH
`define DNSE_ASSERT(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);
`define DNSE_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`else
`define DNSE_ASSERT(lbl, expr, msg)
`define DNSE_ASSERT_IMP(lbl, ante, cons, msg)
`endif

`endif

// ===== design/dnse_pkg.sv =====
`timescale 1ns / 1ps
package dnse_pkg;

   localparam int LABEL_MAX   = 62;
   localparam int LEN_W       = $clog2(LABEL_MAX + 1);
   localparam int IDX_W       = $clog2(LABEL_MAX);
   localparam int CHAR_W      = 8;
   localparam int SPACE_W     = 12;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [SPACE_W-1:0] CAP_RESET = 12'd2031;
   localparam logic [CHAR_W-1:0]  DOT_CHAR  = 8'd46;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NO_SPACE = 2'd1,
      ST_TOO_LONG = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      TAIL_NONE = 2'd0,
      TAIL_TERM = 2'd1,
      TAIL_ERR  = 2'd2
   } tail_type;

   // One queued command: an optional label to emit, then an optional closing result.
   typedef struct packed {
      logic             has_label;
      logic [LEN_W-1:0] label_len;
      tail_type         tail;
      status_type       status;
   } cmd_type;

   typedef struct packed {
      logic              en;
      logic [IDX_W-1:0]  addr;
      logic [CHAR_W-1:0] data;
   } store_wr_type;

endpackage

// ===== design/dnse_front.sv =====
`timescale 1ns / 1ps
module dnse_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  logic [dnse_pkg::CHAR_W-1:0]    in_char,
   input  logic                           in_eon,
   input  logic                           csr_wr_en,
   input  logic [dnse_pkg::SPACE_W-1:0]   csr_wr_data,
   input  logic                           q_full,
   output logic                           q_push,
   output dnse_pkg::cmd_type              q_cmd,
   output dnse_pkg::store_wr_type         store_wr,
   input  logic                           label_done,
   output logic                           store_busy
);

   logic [dnse_pkg::LEN_W-1:0]   len_ff, len_in;
   logic [dnse_pkg::SPACE_W-1:0] space_ff, space_in;
   logic [dnse_pkg::SPACE_W-1:0] cap_ff, cap_in;
   logic                         disc_ff, disc_in;
   logic                         open_ff, open_in;
   logic                         busy_ff, busy_in;

   logic                         accept;
   logic                         is_dot;
   logic [dnse_pkg::LEN_W-1:0]   lab_len;
   logic [dnse_pkg::SPACE_W-1:0] lab_ext;
   logic [dnse_pkg::SPACE_W-1:0] space_after;
   dnse_pkg::status_type         err;
   dnse_pkg::cmd_type            cmd;
   dnse_pkg::store_wr_type       wr;
   logic                         finish;

   assign in_ready   = !busy_ff && !q_full;
   assign accept     = in_valid && in_ready;
   assign is_dot     = (in_char == dnse_pkg::DOT_CHAR);
   // a dot closes the held label; a closing non-dot character adds itself first
   assign lab_len    = is_dot ? len_ff : len_ff + dnse_pkg::LEN_W'(1);
   assign lab_ext    = dnse_pkg::SPACE_W'(lab_len);
   assign store_busy = busy_ff;

   always_comb begin
      len_in      = len_ff;
      space_in    = space_ff;
      cap_in      = cap_ff;
      disc_in     = disc_ff;
      open_in     = open_ff;
      err         = dnse_pkg::ST_OK;
      cmd         = '0;
      wr          = '0;
      finish      = 1'b0;
      space_after = space_ff;
      if (accept) begin
         if (disc_ff) begin
            finish = in_eon;
         end else begin
            open_in = 1'b1;
            if (!is_dot) begin
               if (len_ff >= dnse_pkg::LEN_W'(dnse_pkg::LABEL_MAX)) begin
                  err = dnse_pkg::ST_TOO_LONG;
               end else begin
                  wr.en   = 1'b1;
                  wr.addr = len_ff[dnse_pkg::IDX_W-1:0];
                  wr.data = in_char;
               end
            end
            if ((is_dot || in_eon) && err == dnse_pkg::ST_OK) begin
               if (lab_ext < space_ff) begin
                  cmd.has_label = 1'b1;
                  cmd.label_len = lab_len;
                  space_after   = space_ff - lab_ext - dnse_pkg::SPACE_W'(1);
               end else begin
                  err = dnse_pkg::ST_NO_SPACE;
               end
            end
            if (err == dnse_pkg::ST_OK && in_eon) begin
               if (space_after == '0) begin
                  err = dnse_pkg::ST_NO_SPACE;
               end else begin
                  cmd.tail = dnse_pkg::TAIL_TERM;
                  finish   = 1'b1;
               end
            end
            if (err == dnse_pkg::ST_OK && !in_eon) begin
               space_in = space_after;
               len_in   = is_dot ? '0 : lab_len;
            end
            if (err != dnse_pkg::ST_OK) begin
               cmd.tail   = dnse_pkg::TAIL_ERR;
               cmd.status = err;
               if (in_eon) begin
                  finish = 1'b1;
               end else begin
                  len_in  = '0;
                  disc_in = 1'b1;
               end
            end
         end
      end
      if (finish) begin
         len_in   = '0;
         space_in = cap_ff;
         disc_in  = 1'b0;
         open_in  = 1'b0;
      end
      if (csr_wr_en) begin
         cap_in = csr_wr_data;
         if (!open_ff) begin
            space_in = csr_wr_data;
         end
      end
   end

   assign q_cmd    = cmd;
   assign q_push   = accept && (cmd.has_label || cmd.tail != dnse_pkg::TAIL_NONE);
   assign store_wr = wr;
   // hold the store until the back end has read the queued label out
   assign busy_in  = (busy_ff && !label_done) || (q_push && cmd.has_label);

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff   <= '0;
         space_ff <= dnse_pkg::CAP_RESET;
         cap_ff   <= dnse_pkg::CAP_RESET;
         disc_ff  <= 1'b0;
         open_ff  <= 1'b0;
         busy_ff  <= 1'b0;
      end else begin
         len_ff   <= len_in;
         space_ff <= space_in;
         cap_ff   <= cap_in;
         disc_ff  <= disc_in;
         open_ff  <= open_in;
         busy_ff  <= busy_in;
      end
   end

endmodule

// ===== design/dnse_queue.sv =====
`timescale 1ns / 1ps
module dnse_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  dnse_pkg::cmd_type push_cmd,
   input  logic              pop,
   output dnse_pkg::cmd_type head,
   output logic              empty,
   output logic              full
);

   dnse_pkg::cmd_type             slots_ff [dnse_pkg::QUEUE_DEPTH];
   logic [dnse_pkg::QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [dnse_pkg::QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [dnse_pkg::QCNT_W-1:0]   count_ff, count_in;

   function automatic logic [dnse_pkg::QPTR_W-1:0] next_ptr(
      input logic [dnse_pkg::QPTR_W-1:0] p);
      return (p == dnse_pkg::QPTR_W'(dnse_pkg::QUEUE_DEPTH - 1)) ?
             '0 : p + dnse_pkg::QPTR_W'(1);
   endfunction

   assign empty = (count_ff == '0);
   assign full  = (count_ff == dnse_pkg::QCNT_W'(dnse_pkg::QUEUE_DEPTH));
   assign head  = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + dnse_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - dnse_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== design/dnse_back.sv =====
`timescale 1ns / 1ps
module dnse_back (
   input  logic                         clock,
   input  logic                         reset,
   input  dnse_pkg::store_wr_type       store_wr,
   input  dnse_pkg::cmd_type            head,
   input  logic                         q_empty,
   output logic                         q_pop,
   output logic                         label_done,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic [dnse_pkg::CHAR_W-1:0]  out_byte,
   output dnse_pkg::status_type         out_status,
   output logic                         out_last
);

   typedef enum logic [4:0] {
      B_IDLE = 5'b00001,
      B_LEN  = 5'b00010,
      B_READ = 5'b00100,
      B_DATA = 5'b01000,
      B_TAIL = 5'b10000
   } bstate_type;

   logic [dnse_pkg::CHAR_W-1:0] store_mem [dnse_pkg::LABEL_MAX];
   logic [dnse_pkg::CHAR_W-1:0] rd_data_ff;

   bstate_type                  st_ff, st_in;
   dnse_pkg::cmd_type           cur_ff, cur_in;
   logic [dnse_pkg::IDX_W-1:0]  idx_ff, idx_in;
   logic                        vld_ff, vld_in;
   logic [dnse_pkg::CHAR_W-1:0] byte_ff, byte_in;
   dnse_pkg::status_type        stat_ff, stat_in;
   logic                        last_ff, last_in;

   logic                        slot_free;
   logic                        load;
   bstate_type                  after_label;

   assign slot_free   = !vld_ff || out_ready;
   assign after_label = (cur_ff.tail != dnse_pkg::TAIL_NONE) ? B_TAIL : B_IDLE;

   always_ff @(posedge clock) begin
      if (store_wr.en) begin
         store_mem[store_wr.addr] <= store_wr.data;
      end
      rd_data_ff <= store_mem[idx_ff];
   end

   always_comb begin
      st_in      = st_ff;
      cur_in     = cur_ff;
      idx_in     = idx_ff;
      byte_in    = byte_ff;
      stat_in    = stat_ff;
      last_in    = last_ff;
      load       = 1'b0;
      q_pop      = 1'b0;
      label_done = 1'b0;
      unique case (st_ff)
         B_IDLE: begin
            if (!q_empty) begin
               q_pop  = 1'b1;
               cur_in = head;
               st_in  = head.has_label ? B_LEN : B_TAIL;
            end
         end
         B_LEN: begin
            if (slot_free) begin
               load    = 1'b1;
               byte_in = dnse_pkg::CHAR_W'(cur_ff.label_len);
               stat_in = dnse_pkg::ST_OK;
               last_in = 1'b0;
               idx_in  = '0;
               if (cur_ff.label_len == '0) begin
                  label_done = 1'b1;
                  st_in      = after_label;
               end else begin
                  st_in = B_READ;
               end
            end
         end
         B_READ: begin
            // store data lands in rd_data_ff at this edge
            st_in = B_DATA;
         end
         B_DATA: begin
            if (slot_free) begin
               load    = 1'b1;
               byte_in = rd_data_ff;
               stat_in = dnse_pkg::ST_OK;
               last_in = 1'b0;
               if (dnse_pkg::LEN_W'(idx_ff) + dnse_pkg::LEN_W'(1) == cur_ff.label_len) begin
                  label_done = 1'b1;
                  st_in      = after_label;
               end else begin
                  idx_in = idx_ff + dnse_pkg::IDX_W'(1);
                  st_in  = B_READ;
               end
            end
         end
         B_TAIL: begin
            if (slot_free) begin
               load    = 1'b1;
               byte_in = '0;
               stat_in = (cur_ff.tail == dnse_pkg::TAIL_ERR) ? cur_ff.status : dnse_pkg::ST_OK;
               last_in = 1'b1;
               st_in   = B_IDLE;
            end
         end
         default: st_in = B_IDLE;
      endcase
      vld_in = load ? 1'b1 : (vld_ff && !out_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= B_IDLE;
         vld_ff <= 1'b0;
      end else begin
         st_ff  <= st_in;
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      idx_ff  <= idx_in;
      byte_ff <= byte_in;
      stat_ff <= stat_in;
      last_ff <= last_in;
   end

   assign out_valid  = vld_ff;
   assign out_byte   = byte_ff;
   assign out_status = stat_ff;
   assign out_last   = last_ff;

endmodule

// ===== design/dns_name_label_encoder_core.sv =====
`timescale 1ns / 1ps
// DNS name label encoder: takes a dotted name one character per item on req_ and gives
// wire-format bytes on rsp_ (length byte, label bytes, zero terminator with tlast), or a
// single error item with tlast that ends the name. csr_wr_data sets the output capacity
// in bytes for one name; it loads at once between names and otherwise from the next name.
// A character that extends a label is accepted and written into the label memory. A dot or
// the last character hands the label to the back end, which reads it out of the label memory
// through a registered read: it takes the command from the queue, sends the length byte, then
// for each label byte reads the memory and sends the byte. The input is held while a label is
// read out, and the terminator or error follows the label. Items that cause no label (within a
// label, or dropped after an error) flow at one per cycle while no label is being read out and
// the command queue is not full.
`include "dns_name_label_encoder_core_macros.svh"
module dns_name_label_encoder_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] name_char
   input  logic        req_tlast,   // end_of_name
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] out_byte, [9:8] status, [15:10] zero
   output logic        rsp_tlast,   // last_of_name
   input  logic        csr_wr_en,
   input  logic [11:0] csr_wr_data  // output_capacity
);

   dnse_pkg::cmd_type      q_cmd;
   dnse_pkg::cmd_type      q_head;
   dnse_pkg::store_wr_type store_wr;
   logic                   q_push;
   logic                   q_pop;
   logic                   q_empty;
   logic                   q_full;
   logic                   label_done;
   logic                   store_busy;
   logic [7:0]             out_byte;
   dnse_pkg::status_type   out_status;
   logic                   rsp_err;

   dnse_front u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .in_char     (req_tdata),
      .in_eon      (req_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_cmd       (q_cmd),
      .store_wr    (store_wr),
      .label_done  (label_done),
      .store_busy  (store_busy)
   );

   dnse_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_cmd),
      .pop      (q_pop),
      .head     (q_head),
      .empty    (q_empty),
      .full     (q_full)
   );

   dnse_back u_back (
      .clock      (clock),
      .reset      (reset),
      .store_wr   (store_wr),
      .head       (q_head),
      .q_empty    (q_empty),
      .q_pop      (q_pop),
      .label_done (label_done),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_byte   (out_byte),
      .out_status (out_status),
      .out_last   (rsp_tlast)
   );

   assign rsp_tdata = {6'd0, out_status, out_byte};
   assign rsp_err   = (out_status != dnse_pkg::ST_OK);

   `DNSE_ASSERT(a_label_while_busy, !(store_busy && q_push && q_cmd.has_label), "label in readout")
   `DNSE_ASSERT(a_queue_overflow, !(q_push && q_full), "command queue overflow")
   `DNSE_ASSERT(a_store_write_busy, !(store_busy && store_wr.en), "store written in readout")
   `DNSE_ASSERT_IMP(a_error_ends_name, rsp_tvalid && rsp_err, rsp_tlast, "error without tlast")

endmodule

// ===== verif/dns_name_label_encoder_core_tb.sv =====
`timescale 1ns / 1ps
module dns_name_label_encoder_core_tb;

   localparam int BY_MODEL      = -1;    // row outcome comes from the encoder model
   localparam int TOTAL_ITEMS   = 180;
   localparam int SETTLE_CYCLES = 20;    // extra wait after the last expected byte has been seen
   localparam int HOLD_CYCLES   = 300;
   localparam int END_CYCLES    = 50;
   localparam int QUIET_LIMIT   = 2000;

   typedef struct packed {
      logic [7:0]           out_byte;
      dnse_pkg::status_type status;
      logic                 last;
   } wire_item_type;

   localparam wire_item_type EMPTY_LABEL   = '{8'h00, dnse_pkg::ST_OK, 1'b0};
   localparam wire_item_type NAME_NO_SPACE = '{8'h00, dnse_pkg::ST_NO_SPACE, 1'b1};
   localparam wire_item_type NAME_TOO_LONG = '{8'h00, dnse_pkg::ST_TOO_LONG, 1'b1};

   typedef struct {
      bit            wr_cap;
      logic [11:0]   cap;
      logic [7:0]    ch;
      logic          eon;
      int            reps;
      int            n_typed;
      wire_item_type t0;
      wire_item_type t1;
   } script_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] name_char
   logic        req_tlast;   // end_of_name
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;   // [7:0] out_byte, [9:8] status, [15:10] zero
   logic        rsp_tlast;   // last_of_name
   logic        csr_wr_en;
   logic [11:0] csr_wr_data;

   dns_name_label_encoder_core uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // encoder model state
   logic [7:0]  lbl_mem [dnse_pkg::LABEL_MAX];
   int          lbl_len;
   logic [11:0] room_left;
   logic [11:0] capacity;
   bit          dropping;
   bit          in_name;

   wire_item_type  fresh_q[$];
   wire_item_type  wire_bytes_due[$];
   script_row_type script[$];

   bit steady;
   int holds_asked, holds_served;
   int quiet_cycles;
   int fail_count, items_sent, items_dropped, bytes_checked, cap_writes;
   int names_ok, names_no_space, names_too_long;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic void put_item(logic [7:0] b, dnse_pkg::status_type s, logic l);
      wire_item_type w;
      w.out_byte = b;
      w.status   = s;
      w.last     = l;
      fresh_q.insert(fresh_q.size(), w);
   endfunction

   function automatic void close_name();
      lbl_len   = 0;
      room_left = capacity;
      dropping  = 1'b0;
      in_name   = 1'b0;
   endfunction

   function automatic void set_capacity(logic [11:0] v);
      capacity = v;
      // mid-name the new value waits for the next name
      if (!in_name)
         room_left = v;
   endfunction

   function automatic bit flush_label();
      if (lbl_len >= room_left)
         return 1'b0;
      put_item(8'(lbl_len), dnse_pkg::ST_OK, 1'b0);
      for (int i = 0; i < lbl_len; i++)
         put_item(lbl_mem[i], dnse_pkg::ST_OK, 1'b0);
      room_left = room_left - 12'(lbl_len + 1);
      lbl_len   = 0;
      return 1'b1;
   endfunction

   // Work out the wire bytes one character causes; returns 1 if it is dropped.
   function automatic bit encode_char(logic [7:0] ch, logic eon);
      dnse_pkg::status_type fault;
      fault = dnse_pkg::ST_OK;
      fresh_q.delete();
      if (dropping) begin
         if (eon)
            close_name();
         return 1'b1;
      end
      in_name = 1'b1;
      if (ch == dnse_pkg::DOT_CHAR) begin
         if (!flush_label())
            fault = dnse_pkg::ST_NO_SPACE;
      end else if (lbl_len >= dnse_pkg::LABEL_MAX) begin
         fault = dnse_pkg::ST_TOO_LONG;
      end else begin
         lbl_mem[lbl_len] = ch;
         lbl_len++;
      end
      if (fault == dnse_pkg::ST_OK && eon) begin
         if (ch != dnse_pkg::DOT_CHAR && !flush_label())
            fault = dnse_pkg::ST_NO_SPACE;
         else if (room_left == 0)
            fault = dnse_pkg::ST_NO_SPACE;
         else begin
            put_item(8'h00, dnse_pkg::ST_OK, 1'b1);
            close_name();
            return 1'b0;
         end
      end
      if (fault != dnse_pkg::ST_OK) begin
         put_item(8'h00, fault, 1'b1);
         if (eon)
            close_name();
         else begin
            lbl_len  = 0;
            dropping = 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic void add_row(bit wr, logic [11:0] cap, logic [7:0] ch, logic eon,
                                   int reps, int n_typed, wire_item_type t0,
                                   wire_item_type t1);
      script_row_type r;
      r.wr_cap  = wr;
      r.cap     = cap;
      r.ch      = ch;
      r.eon     = eon;
      r.reps    = reps;
      r.n_typed = n_typed;
      r.t0      = t0;
      r.t1      = t1;
      script.insert(script.size(), r);
   endfunction

   function automatic logic [7:0] label_char();
      logic [7:0] c;
      c = 8'($urandom_range(0, 255));
      if (c == dnse_pkg::DOT_CHAR)
         c = 8'h2D;
      return c;
   endfunction

   function automatic logic [11:0] pick_capacity();
      case ($urandom_range(0, 4))
         0: return 12'd1;
         1: return 12'd4095;
         2: return 12'($urandom_range(2, 40));
         default: return 12'($urandom_range(1, 4095));
      endcase
   endfunction

   task automatic send_char(logic [7:0] ch, logic eon, int n_typed,
                            wire_item_type t0, wire_item_type t1);
      bit ignored;
      @(negedge clock);
      if (!steady && $urandom_range(0, 99) < 17) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = ch;
      req_tlast  = eon;
      do @(posedge clock); while (!req_tready);
      ignored = encode_char(ch, eon);
      items_sent++;
      if (ignored)
         items_dropped++;
      if (n_typed == BY_MODEL) begin
         foreach (fresh_q[i])
            wire_bytes_due.insert(wire_bytes_due.size(), fresh_q[i]);
      end else begin
         if (n_typed >= 1)
            wire_bytes_due.insert(wire_bytes_due.size(), t0);
         if (n_typed >= 2)
            wire_bytes_due.insert(wire_bytes_due.size(), t1);
      end
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (wire_bytes_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_capacity(logic [11:0] v);
      @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = v;
      @(negedge clock);
      csr_wr_en = 1'b0;
      set_capacity(v);
      cap_writes++;
   endtask

   task automatic send_wellformed_name();
      logic [8:0] seq[$];
      int labels, len, pick;
      bit trail;
      labels = $urandom_range(1, 4);
      trail  = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < labels; k++) begin
         pick = $urandom_range(0, 99);
         if (pick < 8)
            len = 0;
         else
            len = $urandom_range(1, 8);
         for (int i = 0; i < len; i++)
            seq.insert(seq.size(), {1'b0, label_char()});
         if (k < labels - 1 || trail)
            seq.insert(seq.size(), {1'b0, dnse_pkg::DOT_CHAR});
      end
      if (seq.size() == 0)
         seq.insert(seq.size(), {1'b0, dnse_pkg::DOT_CHAR});
      seq[seq.size() - 1][8] = 1'b1;
      foreach (seq[i])
         send_char(seq[i][7:0], seq[i][8], BY_MODEL, EMPTY_LABEL, EMPTY_LABEL);
   endtask

   task automatic send_noise();
      logic [7:0] c;
      int n;
      n = $urandom_range(1, 12);
      for (int i = 0; i < n; i++) begin
         c = ($urandom_range(0, 99) < 30) ? dnse_pkg::DOT_CHAR : 8'($urandom_range(0, 255));
         send_char(c, $urandom_range(0, 99) < 8, BY_MODEL, EMPTY_LABEL, EMPTY_LABEL);
      end
   endtask

   task automatic note_fault(string why, wire_item_type want);
      fail_count++;
      if (fail_count <= 10)
         $display("MISMATCH (%s): expected %02h st %0d last %0d, actual %02h st %0d last %0d pad %02h",
                  why, want.out_byte, want.status, want.last,
                  rsp_tdata[7:0], rsp_tdata[9:8], rsp_tlast, rsp_tdata[15:10]);
   endtask

   always @(posedge clock) begin : check_output
      wire_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         bytes_checked++;
         if (wire_bytes_due.size() == 0) begin
            note_fault("nothing pending", EMPTY_LABEL);
         end else begin
            want = wire_bytes_due.pop_front();
            if (rsp_tdata[7:0] !== want.out_byte || rsp_tdata[9:8] !== want.status ||
                rsp_tdata[15:10] !== 6'd0 || rsp_tlast !== want.last)
               note_fault("field", want);
            if (want.last) begin
               case (want.status)
                  dnse_pkg::ST_OK:       names_ok++;
                  dnse_pkg::ST_NO_SPACE: names_no_space++;
                  default:               names_too_long++;
               endcase
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wr_en)
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Timeout: no item moved for %0d cycles", QUIET_LIMIT);
         $display("FAILED: results differ");
         $finish;
      end
   end

   // receiver: random backpressure, one long hold-off on request
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (holds_served < holds_asked) begin
            rsp_tready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            holds_served++;
         end
         rsp_tready = steady || ($urandom_range(0, 99) >= 17);
      end
   end

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = 8'h00;
      req_tlast   = 1'b0;
      csr_wr_en   = 1'b0;
      csr_wr_data = 12'd0;
      steady      = 1'b0;
      capacity    = dnse_pkg::CAP_RESET;
      close_name();

      // leading dot, empty label between dots, char extremes, trailing dot
      add_row(0, 0, dnse_pkg::DOT_CHAR, 0, 1, 1, EMPTY_LABEL, EMPTY_LABEL);
      add_row(0, 0, "a", 0, 1, 0, EMPTY_LABEL, EMPTY_LABEL);
      add_row(0, 0, dnse_pkg::DOT_CHAR, 0, 1, BY_MODEL, EMPTY_LABEL, EMPTY_LABEL);
      add_row(0, 0, dnse_pkg::DOT_CHAR, 0, 1, 1, EMPTY_LABEL, EMPTY_LABEL);
      add_row(0, 0, 8'h00, 0, 1, 0, EMPTY_LABEL, EMPTY_LABEL);
      add_row(0, 0, 8'hFF, 1, 1, BY_MODEL, EMPTY_LABEL, EMPTY_LABEL);
      add_row(0, 0, "b", 0, 1, 0, EMPTY_LABEL, EMPTY_LABEL);
      add_row(0, 0, dnse_pkg::DOT_CHAR, 1, 1, BY_MODEL, EMPTY_LABEL, EMPTY_LABEL);
      // capacity of one: empty label fits but the terminator does not
      add_row(1, 12'd1, dnse_pkg::DOT_CHAR, 1, 1, 2, EMPTY_LABEL, NAME_NO_SPACE);
      add_row(0, 0, "x", 1, 1, 1, NAME_NO_SPACE, EMPTY_LABEL);
      // error mid-name, then drop up to end of name
      add_row(0, 0, "x", 0, 1, 0, EMPTY_LABEL, EMPTY_LABEL);
      add_row(0, 0, dnse_pkg::DOT_CHAR, 0, 1, 1, NAME_NO_SPACE, EMPTY_LABEL);
      add_row(0, 0, "y", 0, 1, 0, EMPTY_LABEL, EMPTY_LABEL);
      add_row(0, 0, "z", 1, 1, 0, EMPTY_LABEL, EMPTY_LABEL);
      // capacity written mid-name applies only to the next name
      add_row(0, 0, "q", 0, 1, 0, EMPTY_LABEL, EMPTY_LABEL);
      add_row(1, 12'd4095, "r", 1, 1, 1, NAME_NO_SPACE, EMPTY_LABEL);
      // label longer than the store, then a full-size label
      add_row(0, 0, "m", 0, dnse_pkg::LABEL_MAX, 0, EMPTY_LABEL, EMPTY_LABEL);
      add_row(0, 0, "n", 0, 1, 1, NAME_TOO_LONG, EMPTY_LABEL);
      add_row(0, 0, "o", 1, 1, 0, EMPTY_LABEL, EMPTY_LABEL);
      add_row(0, 0, "k", 0, dnse_pkg::LABEL_MAX, 0, EMPTY_LABEL, EMPTY_LABEL);
      add_row(0, 0, dnse_pkg::DOT_CHAR, 1, 1, BY_MODEL, EMPTY_LABEL, EMPTY_LABEL);
      // label uses up all space, no room left for the terminator
      add_row(1, 12'd3, "a", 0, 1, 0, EMPTY_LABEL, EMPTY_LABEL);
      add_row(0, 0, "b", 1, 1, BY_MODEL, EMPTY_LABEL, EMPTY_LABEL);

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (script[r]) begin
         if (script[r].wr_cap) begin
            wait_idle();
            write_capacity(script[r].cap);
         end
         // long label rows run with no idling on either side
         steady = (script[r].reps > 1);
         repeat (script[r].reps)
            send_char(script[r].ch, script[r].eon, script[r].n_typed, script[r].t0,
                      script[r].t1);
      end
      steady = 1'b0;

      wait_idle();
      write_capacity(dnse_pkg::CAP_RESET);
      // receiver holds off while the random names keep coming
      holds_asked = 1;
      while (items_sent < TOTAL_ITEMS) begin
         if ($urandom_range(0, 99) < 80)
            send_wellformed_name();
         else
            send_noise();
         if ($urandom_range(0, 99) < 15) begin
            wait_idle();
            write_capacity(pick_capacity());
         end
      end

      @(negedge clock);
      req_tvalid = 1'b0;
      while (wire_bytes_due.size() != 0)
         @(posedge clock);
      repeat (END_CYCLES) @(posedge clock);

      $display("Sent %0d characters (%0d dropped after an error), %0d capacity settings",
               items_sent, items_dropped, cap_writes);
      $display("Checked %0d bytes: %0d names ended, %0d out of space, %0d label too long",
               bytes_checked, names_ok, names_no_space, names_too_long);
      if (fail_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
